FILE: hdl/csvr_pkg.sv
// Shared types and constants for the CSV character parser.
// Beat payloads, dialect register set, register indexes, function and status codes.
// No dependencies.
`default_nettype none

package csvr_pkg;

	localparam int CHAR_W      = 8;
	localparam int QCHAR_W     = 9;
	localparam int LIMIT_W     = 20;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;

	// item function codes
	localparam logic [1:0] FUNC_CHAR = 2'd0;
	localparam logic [1:0] FUNC_EOL  = 2'd1;
	localparam logic [1:0] FUNC_EOI  = 2'd2;

	// result actions
	localparam logic [1:0] ACT_NONE   = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_SAVE   = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_FIELD_LIMIT = 3'd1;
	localparam logic [2:0] ST_QUOTE_EXP   = 3'd2;
	localparam logic [2:0] ST_NL_UNQUOTED = 3'd3;
	localparam logic [2:0] ST_UNEXP_END   = 3'd4;

	// quoting modes that change behaviour
	localparam logic [2:0] MODE_NONE    = 3'd3;
	localparam logic [2:0] MODE_STRINGS = 3'd4;
	localparam logic [2:0] MODE_NOTNULL = 3'd5;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_QUOTE_CHAR  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_CHAR = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_QUOTING     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_QUOTE = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SKIP_SPACE  = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_STRICT      = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_FIELD_LIMIT = 3'd7;

	// characters
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [1:0]        func;
		logic [CHAR_W-1:0] char_code;
	} item_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [CHAR_W-1:0] out_char;
		logic              field_is_null;
		logic              record_done;
		logic              end_of_data;
		logic [2:0]        status;
	} result_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  delimiter;
		logic [QCHAR_W-1:0] quote_char;
		logic [QCHAR_W-1:0] escape_char;
		logic [2:0]         quoting_mode;
		logic               double_quote;
		logic               skip_initial_space;
		logic               strict_mode;
		logic [LIMIT_W-1:0] field_limit;
	} dialect_t;

endpackage

`default_nettype wire

FILE: hdl/csv_reader_char_parser.sv
// Top level of the CSV character parser: input register, beat handshakes, glue.
// Instantiates csvr_cfg_regs and csvr_parser; uses csvr_pkg.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+----------------------------
//   item     | in        | item_valid/item_stall  | csvr_pkg::item_t
//   result   | out       | result_valid/result_stall | csvr_pkg::result_t
//   cfg      | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// One result beat per item beat; each item passes through the input register and the result register.
// Sustained rate is one item per cycle while result_stall is low; the parser step sits between the input
// register and the result register, and the parser state updates at the same edge as the result register.
// Reset returns the dialect registers to their defaults and the parser to start
// of record. A stalled result holds the pipe; item_stall rises only while the
// input register is full and cannot move on. cfg_ready is always high.
`default_nettype none

module csv_reader_char_parser #(
	parameter int LENGTH_BITS = 21
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             item_valid,
	output logic                                  item_stall,
	input  csvr_pkg::item_t                       item,
	output logic                                  result_valid,
	input  wire logic                             result_stall,
	output csvr_pkg::result_t                     result,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [csvr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [csvr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	csvr_pkg::dialect_t dialect;
	csvr_pkg::item_t    item_s1;
	logic               valid_s1, valid_s2, advance, item_take;

	assign advance      = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall   = valid_s1 && !advance;
	assign item_take    = item_valid && !item_stall;
	assign result_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (item_take)    valid_s1 <= 1'b1;
			else if (advance) valid_s1 <= 1'b0;
			if (advance)                     valid_s2 <= 1'b1;
			else if (valid_s2 && !result_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) item_s1 <= item;
	end

	csvr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dialect   (dialect)
	);

	csvr_parser #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item_s1   (item_s1),
		.dialect   (dialect),
		.result_s2 (result)
	);

	a_step_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid
	) else $error("stepped beat did not reach the result register");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall
	) else $error("item stalled with an empty input register");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && result_stall |-> item_stall
	) else $error("item taken while both stages are held");

endmodule

`default_nettype wire

FILE: hdl/csvr_cfg_regs.sv
// Dialect register file for the CSV character parser.
// Holds the eight configuration registers; uses csvr_pkg.
`default_nettype none

module csvr_cfg_regs (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [csvr_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [csvr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output csvr_pkg::dialect_t                      dialect
);

	csvr_pkg::dialect_t dialect_q;

	assign cfg_ready = 1'b1;
	assign dialect   = dialect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dialect_q.delimiter          <= 8'd44;
			dialect_q.quote_char         <= 9'd34;
			dialect_q.escape_char        <= 9'd256;
			dialect_q.quoting_mode       <= 3'd0;
			dialect_q.double_quote       <= 1'b1;
			dialect_q.skip_initial_space <= 1'b0;
			dialect_q.strict_mode        <= 1'b0;
			dialect_q.field_limit        <= 20'd131072;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				csvr_pkg::REG_DELIMITER:    dialect_q.delimiter <= cfg_data[7:0];
				csvr_pkg::REG_QUOTE_CHAR:   dialect_q.quote_char <= cfg_data[8:0];
				csvr_pkg::REG_ESCAPE_CHAR:  dialect_q.escape_char <= cfg_data[8:0];
				csvr_pkg::REG_QUOTING:      dialect_q.quoting_mode <= cfg_data[2:0];
				csvr_pkg::REG_DOUBLE_QUOTE: dialect_q.double_quote <= cfg_data[0];
				csvr_pkg::REG_SKIP_SPACE:   dialect_q.skip_initial_space <= cfg_data[0];
				csvr_pkg::REG_STRICT:       dialect_q.strict_mode <= cfg_data[0];
				csvr_pkg::REG_FIELD_LIMIT:  dialect_q.field_limit <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/csvr_parser.sv
// Parser state machine and result register for the CSV character parser.
// One item per step: next state, field length and result beat; uses csvr_pkg.
`default_nettype none

module csvr_parser #(
	parameter int LENGTH_BITS = 21
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               step,
	input  csvr_pkg::item_t         item_s1,
	input  csvr_pkg::dialect_t      dialect,
	output csvr_pkg::result_t       result_s2
);

	localparam int CmpW = (LENGTH_BITS > csvr_pkg::LIMIT_W) ? LENGTH_BITS : csvr_pkg::LIMIT_W;

	typedef enum logic [3:0] {
		S_START_RECORD    = 4'd0,
		S_START_FIELD     = 4'd1,
		S_ESCAPED_CHAR    = 4'd2,
		S_IN_FIELD        = 4'd3,
		S_IN_QUOTED       = 4'd4,
		S_ESC_IN_QUOTED   = 4'd5,
		S_QUOTE_IN_QUOTED = 4'd6,
		S_EAT_CRNL        = 4'd7,
		S_AFTER_ESC_CRNL  = 4'd8
	} pstate_t;

	pstate_t                 state_q, state_d, st, p_state, put_next, save_next;
	logic                    unq_q, unq_d, p_unq;
	logic [LENGTH_BITS-1:0]  len_q, len_d, p_len;
	csvr_pkg::result_t       res_d;

	logic                    eol, nl, is_quote, is_esc, is_delim, is_space;
	logic                    skip, do_put, do_save, room, null_mode;
	logic [csvr_pkg::CHAR_W-1:0] ch, put_ch, p_ch;
	logic [1:0]              p_act;
	logic [2:0]              p_status;
	logic                    p_null;

	always_comb begin
		ch        = item_s1.char_code;
		eol       = (item_s1.func == csvr_pkg::FUNC_EOL);
		nl        = !eol && (ch == csvr_pkg::CH_LF || ch == csvr_pkg::CH_CR);
		is_quote  = !eol && ({1'b0, ch} == dialect.quote_char) &&
		            (dialect.quoting_mode != csvr_pkg::MODE_NONE);
		is_esc    = !eol && ({1'b0, ch} == dialect.escape_char);
		is_delim  = !eol && (ch == dialect.delimiter);
		is_space  = (ch == csvr_pkg::CH_SPACE);
		room      = !((CmpW'(len_q) >= CmpW'(dialect.field_limit)) || (&len_q));
		null_mode = (dialect.quoting_mode == csvr_pkg::MODE_STRINGS) ||
		            (dialect.quoting_mode == csvr_pkg::MODE_NOTNULL);

		p_state   = state_q;
		p_unq     = unq_q;
		p_len     = len_q;
		p_act     = csvr_pkg::ACT_NONE;
		p_ch      = '0;
		p_null    = 1'b0;
		p_status  = csvr_pkg::ST_OK;
		do_put    = 1'b0;
		do_save   = 1'b0;
		put_ch    = ch;
		put_next  = S_IN_FIELD;
		save_next = S_START_FIELD;
		skip      = 1'b0;
		st        = state_q;

		// record start or after escaped CR/LF: non-line-end chars enter a field
		if (state_q == S_START_RECORD) begin
			if (eol) begin
				skip = 1'b1;
			end else if (nl) begin
				p_state = S_EAT_CRNL;
				skip    = 1'b1;
			end else begin
				st = S_START_FIELD;
			end
		end
		if (state_q == S_AFTER_ESC_CRNL) begin
			if (eol) skip = 1'b1;
			else     st   = S_IN_FIELD;
		end

		if (!skip) begin
			unique case (st)
				S_START_FIELD: begin
					p_state = S_START_FIELD;
					p_unq   = 1'b1;
					if (nl || eol) begin
						do_save   = 1'b1;
						save_next = eol ? S_START_RECORD : S_EAT_CRNL;
					end else if (is_quote) begin
						p_unq   = 1'b0;
						p_state = S_IN_QUOTED;
					end else if (is_esc) begin
						p_state = S_ESCAPED_CHAR;
					end else if (is_space && dialect.skip_initial_space) begin
						p_state = S_START_FIELD;
					end else if (is_delim) begin
						do_save = 1'b1;
					end else begin
						do_put = 1'b1;
					end
				end
				S_ESCAPED_CHAR: begin
					do_put = 1'b1;
					if (nl) put_next = S_AFTER_ESC_CRNL;
					else if (eol) put_ch = csvr_pkg::CH_LF;
				end
				S_IN_FIELD: begin
					if (nl || eol) begin
						do_save   = 1'b1;
						save_next = eol ? S_START_RECORD : S_EAT_CRNL;
					end else if (is_esc) begin
						p_state = S_ESCAPED_CHAR;
					end else if (is_delim) begin
						do_save = 1'b1;
					end else begin
						do_put = 1'b1;
					end
				end
				S_IN_QUOTED: begin
					if (eol) begin
						p_state = S_IN_QUOTED;
					end else if (is_esc) begin
						p_state = S_ESC_IN_QUOTED;
					end else if (is_quote) begin
						p_state = dialect.double_quote ? S_QUOTE_IN_QUOTED : S_IN_FIELD;
					end else begin
						do_put   = 1'b1;
						put_next = S_IN_QUOTED;
					end
				end
				S_ESC_IN_QUOTED: begin
					do_put   = 1'b1;
					put_next = S_IN_QUOTED;
					if (eol) put_ch = csvr_pkg::CH_LF;
				end
				S_QUOTE_IN_QUOTED: begin
					if (is_quote) begin
						do_put   = 1'b1;
						put_next = S_IN_QUOTED;
					end else if (is_delim) begin
						do_save = 1'b1;
					end else if (nl || eol) begin
						do_save   = 1'b1;
						save_next = eol ? S_START_RECORD : S_EAT_CRNL;
					end else if (!dialect.strict_mode) begin
						do_put = 1'b1;
					end else begin
						p_status = csvr_pkg::ST_QUOTE_EXP;
					end
				end
				S_EAT_CRNL: begin
					if (eol) p_state = S_START_RECORD;
					else if (!nl) p_status = csvr_pkg::ST_NL_UNQUOTED;
				end
				default: begin
				end
			endcase
		end

		if (do_put) begin
			if (room) begin
				p_act   = csvr_pkg::ACT_APPEND;
				p_ch    = put_ch;
				p_len   = LENGTH_BITS'(len_q + 1'b1);
				p_state = put_next;
			end else begin
				p_status = csvr_pkg::ST_FIELD_LIMIT;
			end
		end
		if (do_save) begin
			p_act   = csvr_pkg::ACT_SAVE;
			p_null  = p_unq && (len_q == '0) && null_mode;
			p_len   = '0;
			p_state = save_next;
		end

		// resolve by item function
		res_d   = '0;
		state_d = state_q;
		unq_d   = unq_q;
		len_d   = len_q;
		case (item_s1.func)
			csvr_pkg::FUNC_CHAR, csvr_pkg::FUNC_EOL: begin
				if (p_status != csvr_pkg::ST_OK) begin
					res_d.status = p_status;
					state_d      = S_START_RECORD;
					unq_d        = 1'b0;
					len_d        = '0;
				end else begin
					res_d.action        = p_act;
					res_d.out_char      = p_ch;
					res_d.field_is_null = p_null;
					res_d.record_done   = eol && (p_state == S_START_RECORD);
					state_d             = p_state;
					unq_d               = p_unq;
					len_d               = p_len;
				end
			end
			csvr_pkg::FUNC_EOI: begin
				if ((len_q != '0) || (state_q == S_IN_QUOTED)) begin
					if (dialect.strict_mode) begin
						res_d.status = csvr_pkg::ST_UNEXP_END;
					end else begin
						res_d.action        = csvr_pkg::ACT_SAVE;
						res_d.field_is_null = unq_q && (len_q == '0) && null_mode;
						res_d.record_done   = 1'b1;
					end
				end else begin
					res_d.end_of_data = 1'b1;
				end
				state_d = S_START_RECORD;
				unq_d   = 1'b0;
				len_d   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START_RECORD;
			unq_q   <= 1'b0;
			len_q   <= '0;
		end else if (step) begin
			state_q <= state_d;
			unq_q   <= unq_d;
			len_q   <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) result_s2 <= res_d;
	end

	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res_d.status != csvr_pkg::ST_OK) |=> (state_q == S_START_RECORD) && (len_q == '0)
	) else $error("parser state not cleared after an error");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && (item_s1.func == csvr_pkg::FUNC_EOI) |=> (state_q == S_START_RECORD) && !unq_q
	) else $error("parser state not cleared at end of input");

	a_append_counts: assert property (@(posedge clk) disable iff (!arst_n)
		step && (res_d.action == csvr_pkg::ACT_APPEND) |=>
			(len_q == LENGTH_BITS'($past(len_q) + 1'b1))
	) else $error("field length did not advance on append");

endmodule

`default_nettype wire

FILE: tb/csv_reader_char_parser_tb.sv
// Self-checking bench for csv_reader_char_parser: a directed table, then four dialect phases
// of random CSV records and noise, checked beat by beat against table entries or a behavioural parser model.
// Depends on csvr_pkg and the RTL under hdl/.

module csv_reader_char_parser_tb;
	import csvr_pkg::*;

	localparam logic [1:0] FUNC_UNUSED     = 2'd3;
	localparam logic [2:0] MODE_MINIMAL    = 3'd0;
	localparam logic [2:0] MODE_UNUSED_6   = 3'd6;
	localparam logic [2:0] MODE_UNUSED_7   = 3'd7;
	localparam logic [8:0] NO_CHAR         = 9'h100;
	localparam int         HOLD_CYCLES     = 80;
	localparam int         PHASE_ITEMS     = 125;

	typedef enum logic [3:0] {
		PS_START_RECORD, PS_START_FIELD, PS_ESCAPED, PS_IN_FIELD, PS_IN_QUOTED,
		PS_ESC_IN_QUOTED, PS_QUOTE_IN_QUOTED, PS_EAT_CRNL, PS_AFTER_ESC_CRNL
	} pstate_e;

	typedef struct {
		bit          is_cfg;
		logic [2:0]  idx;
		logic [19:0] val;
		item_t       it;
		bit          fixed;
		result_t     want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [19:0] cfg_data = '0;

	// parser model state and dialect copy
	dialect_t    dia;
	pstate_e     ps;
	logic        unq;
	logic [20:0] flen;
	result_t     step_res;

	result_t     results_due[$];
	dir_row_t    dir_rows[$];
	int          items_sent = 0;
	int          results_checked = 0;
	int          mismatches = 0;
	int          input_held_cycles = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	csv_reader_char_parser DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		#(12 * 500000);
		$display("TEST FAILED");
		$finish;
	end

	// ---------------- parser model ----------------

	function void clear_parse();
		ps = PS_START_RECORD;
		unq = 1'b0;
		flen = '0;
	endfunction

	function void put_ch(logic [7:0] c, pstate_e nxt);
		if (flen >= {1'b0, dia.field_limit} || &flen) begin
			step_res.status = ST_FIELD_LIMIT;
		end else begin
			step_res.action = ACT_APPEND;
			step_res.out_char = c;
			flen = flen + 1'b1;
			ps = nxt;
		end
	endfunction

	function void save_fld(pstate_e nxt);
		step_res.action = ACT_SAVE;
		step_res.field_is_null = unq && flen == 0 &&
			(dia.quoting_mode == MODE_STRINGS || dia.quoting_mode == MODE_NOTNULL);
		flen = '0;
		ps = nxt;
	endfunction

	function void parse_char(logic eol, logic [7:0] c);
		logic    nl, qt, esc, dl;
		pstate_e st;
		nl = !eol && (c == CH_LF || c == CH_CR);
		qt = !eol && {1'b0, c} == dia.quote_char && dia.quoting_mode != MODE_NONE;
		esc = !eol && {1'b0, c} == dia.escape_char;
		dl = !eol && c == dia.delimiter;
		st = ps;
		if (st == PS_START_RECORD) begin
			if (eol)
				return;
			if (nl) begin
				ps = PS_EAT_CRNL;
				return;
			end
			st = PS_START_FIELD;
		end
		if (st == PS_AFTER_ESC_CRNL) begin
			if (eol)
				return;
			st = PS_IN_FIELD;
		end
		case (st)
			PS_START_FIELD: begin
				ps = PS_START_FIELD;
				unq = 1'b1;
				if (nl || eol)
					save_fld(eol ? PS_START_RECORD : PS_EAT_CRNL);
				else if (qt) begin
					unq = 1'b0;
					ps = PS_IN_QUOTED;
				end else if (esc)
					ps = PS_ESCAPED;
				else if (c == CH_SPACE && dia.skip_initial_space)
					;
				else if (dl)
					save_fld(PS_START_FIELD);
				else
					put_ch(c, PS_IN_FIELD);
			end
			PS_ESCAPED: begin
				if (nl)
					put_ch(c, PS_AFTER_ESC_CRNL);
				else
					put_ch(eol ? CH_LF : c, PS_IN_FIELD);
			end
			PS_IN_FIELD: begin
				if (nl || eol)
					save_fld(eol ? PS_START_RECORD : PS_EAT_CRNL);
				else if (esc)
					ps = PS_ESCAPED;
				else if (dl)
					save_fld(PS_START_FIELD);
				else
					put_ch(c, PS_IN_FIELD);
			end
			PS_IN_QUOTED: begin
				if (eol)
					;
				else if (esc)
					ps = PS_ESC_IN_QUOTED;
				else if (qt)
					ps = dia.double_quote ? PS_QUOTE_IN_QUOTED : PS_IN_FIELD;
				else
					put_ch(c, PS_IN_QUOTED);
			end
			PS_ESC_IN_QUOTED: put_ch(eol ? CH_LF : c, PS_IN_QUOTED);
			PS_QUOTE_IN_QUOTED: begin
				if (qt)
					put_ch(c, PS_IN_QUOTED);
				else if (dl)
					save_fld(PS_START_FIELD);
				else if (nl || eol)
					save_fld(eol ? PS_START_RECORD : PS_EAT_CRNL);
				else if (!dia.strict_mode)
					put_ch(c, PS_IN_FIELD);
				else
					step_res.status = ST_QUOTE_EXP;
			end
			PS_EAT_CRNL: begin
				if (nl)
					;
				else if (eol)
					ps = PS_START_RECORD;
				else
					step_res.status = ST_NL_UNQUOTED;
			end
			default: ;
		endcase
	endfunction

	function result_t next_parse_result(item_t it);
		step_res = '0;
		case (it.func)
			FUNC_CHAR, FUNC_EOL: begin
				parse_char(it.func == FUNC_EOL, it.char_code);
				if (step_res.status != ST_OK) begin
					step_res.action = ACT_NONE;
					clear_parse();
				end else if (it.func == FUNC_EOL && ps == PS_START_RECORD) begin
					step_res.record_done = 1'b1;
				end
			end
			FUNC_EOI: begin
				if (flen != 0 || ps == PS_IN_QUOTED) begin
					if (dia.strict_mode)
						step_res.status = ST_UNEXP_END;
					else begin
						save_fld(PS_START_RECORD);
						step_res.record_done = 1'b1;
					end
				end else begin
					step_res.end_of_data = 1'b1;
				end
				clear_parse();
			end
			default: ;
		endcase
		if (step_res.action != ACT_APPEND)
			step_res.out_char = '0;
		if (step_res.action != ACT_SAVE)
			step_res.field_is_null = 1'b0;
		return step_res;
	endfunction

	// ---------------- checking ----------------

	function void check_field(string fname, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && item_valid && item_stall)
			input_held_cycles++;
		if (arst_n && result_valid && !result_stall) begin
			if (results_due.size() == 0) begin
				$error("result beat with nothing outstanding: %p", result);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				check_field("action", want.action, result.action);
				check_field("out_char", want.out_char, result.out_char);
				check_field("field_is_null", want.field_is_null, result.field_is_null);
				check_field("record_done", want.record_done, result.record_done);
				check_field("end_of_data", want.end_of_data, result.end_of_data);
				check_field("status", want.status, result.status);
				results_checked++;
			end
		end
	end

	// output back-pressure; a long hold is counted down here when requested
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// ---------------- drivers ----------------

	task automatic push_item(item_t it, bit fixed, result_t want);
		result_t r;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		r = next_parse_result(it);
		results_due.push_back(fixed ? want : r);
		if (it.func != FUNC_UNUSED)
			items_sent++;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic feed(logic [1:0] f, logic [7:0] c);
		push_item(item_t'{f, c}, 1'b0, '0);
	endtask

	task automatic wait_results_home();
		item_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] val, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DELIMITER:    dia.delimiter = val[7:0];
			REG_QUOTE_CHAR:   dia.quote_char = val[8:0];
			REG_ESCAPE_CHAR:  dia.escape_char = val[8:0];
			REG_QUOTING:      dia.quoting_mode = val[2:0];
			REG_DOUBLE_QUOTE: dia.double_quote = val[0];
			REG_SKIP_SPACE:   dia.skip_initial_space = val[0];
			REG_STRICT:       dia.strict_mode = val[0];
			REG_FIELD_LIMIT:  dia.field_limit = val;
			default: ;
		endcase
		if (last)
			cfg_valid <= 1'b0;
	endtask

	task automatic set_dialect(dialect_t d);
		write_reg(REG_DELIMITER, 20'(d.delimiter), 1'b0);
		write_reg(REG_QUOTE_CHAR, 20'(d.quote_char), 1'b0);
		write_reg(REG_ESCAPE_CHAR, 20'(d.escape_char), 1'b0);
		write_reg(REG_QUOTING, 20'(d.quoting_mode), 1'b0);
		write_reg(REG_DOUBLE_QUOTE, 20'(d.double_quote), 1'b0);
		write_reg(REG_SKIP_SPACE, 20'(d.skip_initial_space), 1'b0);
		write_reg(REG_STRICT, 20'(d.strict_mode), 1'b0);
		write_reg(REG_FIELD_LIMIT, d.field_limit, 1'b1);
	endtask

	// One well-formed-ish record of random content, or a burst of noise.
	task automatic random_record();
		int         nf, len, kind;
		bit         has_q, has_e;
		logic [7:0] q, e;
		has_q = dia.quote_char < NO_CHAR && dia.quoting_mode != MODE_NONE;
		has_e = dia.escape_char < NO_CHAR;
		q = dia.quote_char[7:0];
		e = dia.escape_char[7:0];
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 6))
				feed($urandom_range(0, 3), $urandom_range(0, 255));
			return;
		end
		nf = $urandom_range(1, 4);
		for (int i = 0; i < nf; i++) begin
			if (i != 0)
				feed(FUNC_CHAR, dia.delimiter);
			if (dia.skip_initial_space && $urandom_range(0, 3) == 0)
				feed(FUNC_CHAR, CH_SPACE);
			kind = $urandom_range(0, 9);
			len = $urandom_range(0, 5);
			if (kind < 4 || (kind < 7 && !has_q) || (kind == 7 && !has_e)) begin
				repeat (len)
					feed(FUNC_CHAR, $urandom_range(97, 122));
			end else if (kind < 7) begin
				feed(FUNC_CHAR, q);
				repeat (len) begin
					case ($urandom_range(0, 7))
						0: begin
							feed(FUNC_CHAR, q);
							feed(FUNC_CHAR, q);
						end
						1: feed(FUNC_CHAR, dia.delimiter);
						2: feed(FUNC_CHAR, CH_LF);
						3: begin
							if (has_e)
								feed(FUNC_CHAR, e);
							feed(FUNC_CHAR, $urandom_range(0, 255));
						end
						default: feed(FUNC_CHAR, $urandom_range(97, 122));
					endcase
				end
				// sometimes left open, sometimes junk after the closing quote
				if ($urandom_range(0, 7) != 0)
					feed(FUNC_CHAR, q);
				if ($urandom_range(0, 5) == 0)
					feed(FUNC_CHAR, $urandom_range(97, 122));
			end else if (kind == 7) begin
				feed(FUNC_CHAR, e);
				feed(FUNC_CHAR, $urandom_range(0, 255));
				repeat (len)
					feed(FUNC_CHAR, $urandom_range(97, 122));
			end else if (kind == 8) begin
				feed(FUNC_CHAR, $urandom_range(0, 255));
			end
		end
		case ($urandom_range(0, 9))
			5, 6: feed(FUNC_CHAR, CH_LF);
			7: begin
				feed(FUNC_CHAR, CH_CR);
				feed(FUNC_CHAR, CH_LF);
			end
			8: feed(FUNC_EOI, $urandom_range(0, 255));
			9: begin
				feed(FUNC_CHAR, CH_CR);
				feed(FUNC_EOL, $urandom_range(0, 255));
			end
			default: feed(FUNC_EOL, $urandom_range(0, 255));
		endcase
	endtask

	function dir_row_t cfg_row(logic [2:0] idx, logic [19:0] val);
		dir_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function dir_row_t item_row(logic [1:0] f, logic [7:0] c, bit fixed = 1'b0,
			result_t want = '0);
		dir_row_t r;
		r = '{default: '0};
		r.it = item_t'{f, c};
		r.fixed = fixed;
		r.want = want;
		return r;
	endfunction

	// ---------------- sequence ----------------

	initial begin
		bit       held, paused;
		int       phase_start;
		dialect_t phase_dia;
		dia = dialect_t'{8'd44, 9'd34, NO_CHAR, MODE_MINIMAL, 1'b1, 1'b0, 1'b0, 20'd131072};
		clear_parse();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_rows = '{
			item_row(FUNC_EOL, 8'h00, 1, result_t'{ACT_NONE, 8'h00, 1'b0, 1'b1, 1'b0, ST_OK}),
			item_row(FUNC_EOI, 8'hff, 1, result_t'{ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b1, ST_OK}),
			item_row(FUNC_CHAR, "a", 1, result_t'{ACT_APPEND, "a", 1'b0, 1'b0, 1'b0, ST_OK}),
			item_row(FUNC_CHAR, ",", 1, result_t'{ACT_SAVE, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK}),
			item_row(FUNC_CHAR, "\""),
			item_row(FUNC_CHAR, 8'hff, 1, result_t'{ACT_APPEND, 8'hff, 1'b0, 1'b0, 1'b0, ST_OK}),
			item_row(FUNC_CHAR, "\""),
			item_row(FUNC_CHAR, "\""),
			item_row(FUNC_CHAR, "\""),
			item_row(FUNC_CHAR, "x"),
			item_row(FUNC_CHAR, CH_LF),
			item_row(FUNC_CHAR, 8'h00, 1,
				result_t'{ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ST_NL_UNQUOTED}),
			item_row(FUNC_UNUSED, 8'hff, 1, result_t'{ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ST_OK}),
			item_row(FUNC_CHAR, "\""),
			item_row(FUNC_EOI, 8'h00, 1, result_t'{ACT_SAVE, 8'h00, 1'b0, 1'b1, 1'b0, ST_OK}),
			cfg_row(REG_STRICT, 20'd1),
			item_row(FUNC_CHAR, "\""),
			item_row(FUNC_EOI, 8'h00, 1,
				result_t'{ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ST_UNEXP_END}),
			item_row(FUNC_CHAR, "\""),
			item_row(FUNC_CHAR, "\""),
			item_row(FUNC_CHAR, "b", 1,
				result_t'{ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ST_QUOTE_EXP}),
			cfg_row(REG_FIELD_LIMIT, 20'd0),
			cfg_row(REG_QUOTING, 20'(MODE_NOTNULL)),
			item_row(FUNC_CHAR, "c", 1,
				result_t'{ACT_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ST_FIELD_LIMIT}),
			item_row(FUNC_CHAR, ",", 1, result_t'{ACT_SAVE, 8'h00, 1'b1, 1'b0, 1'b0, ST_OK}),
			cfg_row(REG_FIELD_LIMIT, 20'hfffff),
			cfg_row(REG_ESCAPE_CHAR, 20'h05c),
			cfg_row(REG_SKIP_SPACE, 20'd1),
			cfg_row(REG_DOUBLE_QUOTE, 20'd0),
			cfg_row(REG_DELIMITER, 20'h03b),
			cfg_row(REG_QUOTE_CHAR, 20'h1ff),
			cfg_row(REG_QUOTING, 20'(MODE_UNUSED_7)),
			item_row(FUNC_CHAR, CH_SPACE),
			item_row(FUNC_CHAR, "\\"),
			item_row(FUNC_EOL, 8'h55)
		};
		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				wait_results_home();
				write_reg(dir_rows[i].idx, dir_rows[i].val,
					i == dir_rows.size() - 1 || !dir_rows[i + 1].is_cfg);
			end else begin
				push_item(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].want);
			end
		end

		held = 1'b0;
		paused = 1'b0;
		for (int p = 0; p < 4; p++) begin
			wait_results_home();
			case (p)
				0: begin
					phase_dia = dialect_t'{8'h2c, 9'h022, NO_CHAR, MODE_UNUSED_6,
						1'b1, 1'b0, 1'b0, 20'hfffff};
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					phase_dia = dialect_t'{8'h3b, 9'h027, 9'h05c, MODE_STRINGS,
						1'b0, 1'b1, 1'b1, 20'd4};
					send_idle_pct = 49;
					stall_pct = 0;
				end
				2: begin
					phase_dia = dialect_t'{8'hff, 9'h1ff, 9'h000, MODE_NONE,
						1'b1, 1'b0, 1'b0, 20'd7};
					send_idle_pct = 0;
					stall_pct = 49;
				end
				default: begin
					phase_dia = dialect_t'{8'h09, 9'h022, NO_CHAR, MODE_NOTNULL,
						1'b1, 1'b1, 1'b1, 20'd16};
					send_idle_pct = 20;
					stall_pct = 20;
				end
			endcase
			set_dialect(phase_dia);
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				random_record();
				// long output hold while items keep coming, so the input side backs up
				if (p == 0 && !held && items_sent - phase_start >= 40) begin
					hold_req++;
					held = 1'b1;
				end
				if (p == 3 && !paused && items_sent - phase_start >= 60) begin
					wait_results_home();
					paused = 1'b1;
				end
			end
		end

		wait_results_home();
		repeat (8) @(posedge clk);
		$display("Summary: %0d items over a directed table and four dialect phases,", items_sent);
		$display("  %0d result beats checked, input held off for %0d cycles.",
			results_checked, input_held_cycles);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
